// ===== hw/rtl/tlf_pkg.sv =====
// Package for the text line folder: widths, character codes, cell control
// and sequencer state types. No dependencies.
`default_nettype none

package tlf_pkg;

  localparam int FOLD_WIDTH = 8;
  localparam int SEG_DEPTH  = FOLD_WIDTH + 1;
  localparam int CNT_W      = $clog2(SEG_DEPTH + 1);

  localparam logic [7:0] CH_BLANK = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;

  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FOLD,
    ST_DROP,
    ST_FLUSH
  } fsm_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tlf_ifs.sv =====
// Valid/ready channel interfaces for the text line folder.
// Depends on nothing but plain logic types.
`default_nettype none

interface tlf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_input;

  modport source (output valid, output char_in, output end_of_input, input ready);
  modport sink   (input valid, input char_in, input end_of_input, output ready);
endinterface

interface tlf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       last_of_run;

  modport source (output valid, output char_out, output last_of_run, input ready);
  modport sink   (input valid, input char_out, input last_of_run, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tlf_cell.sv =====
// One segment cell: a byte that loads from the write port or shifts in
// from its right neighbor, and flags blank, tab or newline. Uses tlf_pkg.
`default_nettype none

module tlf_cell (
  input  logic              clk,
  input  tlf_pkg::cell_ctl_t ctl,
  input  logic [7:0]        load_data,
  input  logic [7:0]        right_data,
  output logic [7:0]        data,
  output logic              is_break
);
  import tlf_pkg::*;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      data <= load_data;
    end else if (ctl.shift) begin
      data <= right_data;
    end
  end

  assign is_break = (data == CH_BLANK) || (data == CH_TAB) || (data == CH_NL);

endmodule

`default_nettype wire

// ===== hw/rtl/text_line_folder.sv =====
// Top level of the text line folder: row of segment cells, fold sequencer
// and output register. Uses tlf_pkg, tlf_ifs and tlf_cell.
//
//  channel       dir  beat payload                    
//  char_stream   in   char_in[7:0], end_of_input       
//  folded        out  char_out[7:0], last_of_run       
//
// A character that causes no output is taken at once; the next can follow
// directly. A fold emits b+1 beats (or FOLD_WIDTH), then drops the blank
// it broke at, if any; a flush emits one beat per buffered character.
// Characters leave from cell 0, a fold's newline is inserted; all beats
// pass one output register, one per cycle unless stalled. rst clears
// the fill count, sequencer and output valid; cell bytes are not reset.
// A folded stall freezes register and emitting shifts, not the blank drop.
`default_nettype none

module text_line_folder (
  input  logic     clk,
  input  logic     rst,
  tlf_in_if.sink   char_stream,
  tlf_out_if.source folded
);
  import tlf_pkg::*;

  fsm_t state, state_next;
  cnt_t count, count_next;
  cnt_t fold_left, fold_left_next;
  logic drop, drop_next;
  logic flush_pend, flush_next;

  logic [7:0] cell_data [SEG_DEPTH];
  logic       cell_brk  [SEG_DEPTH];
  cell_ctl_t  cell_ctl  [SEG_DEPTH];

  logic       shift, load_en, emit, emit_last, in_ready, in_fire, out_free;
  logic [7:0] emit_char;
  cnt_t       brk_pos;

  logic       ov;
  logic [7:0] ochar;
  logic       olast;

  genvar i;
  generate
    for (i = 0; i < SEG_DEPTH; i++) begin : g_cell
      assign cell_ctl[i].load  = load_en && (count == CNT_W'(i));
      assign cell_ctl[i].shift = shift;
      if (i == SEG_DEPTH - 1) begin : g_end
        tlf_cell u_cell (
          .clk       (clk),
          .ctl       (cell_ctl[i]),
          .load_data (char_stream.char_in),
          .right_data(cell_data[i]),
          .data      (cell_data[i]),
          .is_break  (cell_brk[i])
        );
      end else begin : g_mid
        tlf_cell u_cell (
          .clk       (clk),
          .ctl       (cell_ctl[i]),
          .load_data (char_stream.char_in),
          .right_data(cell_data[i+1]),
          .data      (cell_data[i]),
          .is_break  (cell_brk[i])
        );
      end
    end
  endgenerate

  // highest break offset in 1..FOLD_WIDTH-1, zero when none
  always_comb begin
    brk_pos = '0;
    for (int k = 1; k < FOLD_WIDTH; k++) begin
      if (cell_brk[k]) brk_pos = CNT_W'(k);
    end
  end

  assign out_free          = !ov || folded.ready;
  assign in_fire           = char_stream.valid && in_ready;
  assign char_stream.ready = in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      fold_left  <= '0;
      drop       <= 1'b0;
      flush_pend <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      fold_left  <= fold_left_next;
      drop       <= drop_next;
      flush_pend <= flush_next;
    end
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    fold_left_next = fold_left;
    drop_next      = drop;
    flush_next     = flush_pend;
    shift          = 1'b0;
    load_en        = 1'b0;
    emit           = 1'b0;
    emit_char      = cell_data[0];
    emit_last      = 1'b0;
    in_ready       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          if (char_stream.end_of_input) begin
            if (count != '0) state_next = ST_FLUSH;
          end else begin
            load_en = 1'b1;
            if (count == CNT_W'(SEG_DEPTH - 1)) begin
              count_next     = CNT_W'(SEG_DEPTH);
              drop_next      = (brk_pos != '0);
              fold_left_next = (brk_pos != '0) ? brk_pos : CNT_W'(FOLD_WIDTH - 1);
              flush_next     = (char_stream.char_in == CH_NL);
              state_next     = ST_FOLD;
            end else begin
              count_next = count + CNT_W'(1);
              if (char_stream.char_in == CH_NL) state_next = ST_FLUSH;
            end
          end
        end
      end
      ST_FOLD: begin
        if (out_free) begin
          emit = 1'b1;
          if (fold_left != '0) begin
            shift          = 1'b1;
            count_next     = count - CNT_W'(1);
            fold_left_next = fold_left - CNT_W'(1);
          end else begin
            emit_char = CH_NL;
            emit_last = !flush_pend;
            if (drop)            state_next = ST_DROP;
            else if (flush_pend) state_next = ST_FLUSH;
            else                 state_next = ST_IDLE;
          end
        end
      end
      ST_DROP: begin
        // discard the blank that the fold broke at
        shift      = 1'b1;
        count_next = count - CNT_W'(1);
        state_next = flush_pend ? ST_FLUSH : ST_IDLE;
      end
      ST_FLUSH: begin
        if (out_free) begin
          emit       = 1'b1;
          shift      = 1'b1;
          count_next = count - CNT_W'(1);
          emit_last  = (count == CNT_W'(1));
          if (count == CNT_W'(1)) state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (emit) begin
      ov <= 1'b1;
    end else if (folded.ready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      ochar <= emit_char;
      olast <= emit_last;
    end
  end

  assign folded.valid       = ov;
  assign folded.char_out    = ochar;
  assign folded.last_of_run = olast;

endmodule

`default_nettype wire

// ===== hw/rtl/tlf_checker.sv =====
// Port-level checks for the text line folder, bound to the top level.
// Depends on tlf_pkg, text_line_folder and the channel interfaces.
`default_nettype none

module tlf_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] in_char,
  input logic       in_eoi,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       out_last
);
  import tlf_pkg::*;

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_last))
    else $error("output beat changed under stall");

  // a run in progress blocks new input
  a_run_blocks: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_last |-> !in_ready)
    else $error("input taken in the middle of a run");

  // a newline blocks input: it starts a flush, or a fold that ends in one
  a_nl_flush: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !in_eoi && (in_char == CH_NL) |=> !in_ready)
    else $error("newline did not start a flush");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind text_line_folder tlf_checker u_tlf_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (char_stream.valid),
  .in_ready (char_stream.ready),
  .in_char  (char_stream.char_in),
  .in_eoi   (char_stream.end_of_input),
  .out_valid(folded.valid),
  .out_ready(folded.ready),
  .out_char (folded.char_out),
  .out_last (folded.last_of_run)
);

`default_nettype wire
